### rtl/core/srtd_pkg.sv
// shared types and constants for the sntp reply time decoder
`timescale 1ns / 1ps
`default_nettype none

package srtd_pkg;

    // longest reply payload that is still decoded
    localparam logic [10:0] MAX_PACKET_BYTES = 11'd68;

    // seconds from 1900-01-01 to 1970-01-01
    localparam logic [31:0] UNIX_OFFSET = 32'd2208988800;

    // kiss-of-death holdoff length in microseconds
    localparam logic [63:0] HOLDOFF_US = 64'd60000000;

    // weight of the top fraction bit, halved with truncation per bit
    localparam logic [19:0] FIRST_WEIGHT = 20'd500000;
    localparam int          FRAC_BITS    = 19;

    // action codes of a result item
    typedef enum logic [2:0] {
        ACT_TOO_LONG   = 3'd0,
        ACT_WRONG_MODE = 3'd1,
        ACT_KOD        = 3'd2,
        ACT_TIME_SET   = 3'd3,
        ACT_TICK_HOLD  = 3'd4,
        ACT_TICK_REQ   = 3'd5
    } t_action;

    // opcode of an input item
    localparam logic OP_REPLY = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // one input item as held in the input register
    typedef struct packed {
        logic        opcode;
        logic [10:0] packet_length;
        logic [7:0]  mode_byte;
        logic [7:0]  stratum;
        logic [31:0] tx_seconds;
        logic [31:0] tx_fraction;
        logic [62:0] now_us;
    } t_in_item;

    // request from the decode logic to the holdoff tracker
    typedef struct packed {
        logic        fire;
        logic        tick;
        logic        kod;
        logic [62:0] now_us;
    } t_hold_req;

endpackage

`default_nettype wire

### rtl/core/srtd_in_if.sv
// input channel: valid/ready handshake with the item fields
`timescale 1ns / 1ps
`default_nettype none

interface srtd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [10:0] packet_length;
    logic [7:0]  mode_byte;
    logic [7:0]  stratum;
    logic [31:0] tx_seconds;
    logic [31:0] tx_fraction;
    logic [62:0] now_us;

    modport source (
        output valid, opcode, packet_length, mode_byte, stratum,
               tx_seconds, tx_fraction, now_us,
        input  ready
    );

    modport sink (
        input  valid, opcode, packet_length, mode_byte, stratum,
               tx_seconds, tx_fraction, now_us,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/srtd_out_if.sv
// output channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps
`default_nettype none

interface srtd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic signed [31:0] unix_seconds;
    logic [19:0]        microseconds;

    modport source (
        output valid, action, unix_seconds, microseconds,
        input  ready
    );

    modport sink (
        input  valid, action, unix_seconds, microseconds,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/srtd_frac_conv.sv
// ntp binary fraction to microseconds by a sum of halving weights
`timescale 1ns / 1ps
`default_nettype none

module srtd_frac_conv
    import srtd_pkg::*;
(
    input  wire logic [31:0] i_fraction,
    output logic      [19:0] o_microseconds
);

    // top fraction bits each add a fixed weight, no carry into bit 20
    always_comb begin
        logic [19:0] sum;
        sum = '0;
        for (int k = 0; k < FRAC_BITS; k++) begin
            if (i_fraction[31 - k]) begin
                sum = sum + (FIRST_WEIGHT >> k);
            end
        end
        o_microseconds = sum;
    end

endmodule

`default_nettype wire

### rtl/core/srtd_holdoff.sv
// kiss-of-death holdoff deadline tracker
`timescale 1ns / 1ps
`default_nettype none

module srtd_holdoff
    import srtd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_hold_req i_req,
    output logic           o_armed
);

    logic [63:0] r_deadline;
    logic [63:0] n_deadline;

    assign o_armed = (r_deadline != '0);

    // arm on kiss-of-death, clear on a tick past the deadline
    always_comb begin
        n_deadline = r_deadline;
        if (i_req.fire) begin
            if (i_req.kod) begin
                n_deadline = {1'b0, i_req.now_us} + HOLDOFF_US;
            end else if (i_req.tick && o_armed &&
                         ({1'b0, i_req.now_us} > r_deadline)) begin
                n_deadline = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else begin
            r_deadline <= n_deadline;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sntp_reply_time_decoder.sv
// sntp reply time decoder top level
// an item passes the input register and then the result register before its result can be taken
// throughput: one item per cycle while results are taken; input ready follows the result register's room
// the holdoff deadline is updated as an item leaves the input register
// reset (synchronous, active low) empties both registers and clears the holdoff
`timescale 1ns / 1ps
`default_nettype none

module sntp_reply_time_decoder
    import srtd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srtd_in_if.sink   i_in,
    srtd_out_if.source o_out
);

    // input register
    logic     r_s1_valid;
    t_in_item r_s1;
    logic     s1_adv;

    // result register
    logic               r_out_valid;
    t_action            r_out_action;
    logic signed [31:0] r_out_secs;
    logic [19:0]        r_out_us;

    // decode results
    t_action            n_action;
    logic signed [31:0] n_secs;
    logic [19:0]        n_us;
    logic [19:0]        frac_us;
    logic [31:0]        era_secs;
    logic               too_long;
    logic               mode_ok;
    logic               armed;
    t_hold_req          hold_req;

    // handshake: item moves on when the result register has room
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1.opcode        <= i_in.opcode;
            r_s1.packet_length <= i_in.packet_length;
            r_s1.mode_byte     <= i_in.mode_byte;
            r_s1.stratum       <= i_in.stratum;
            r_s1.tx_seconds    <= i_in.tx_seconds;
            r_s1.tx_fraction   <= i_in.tx_fraction;
            r_s1.now_us        <= i_in.now_us;
        end
    end

    // fraction conversion
    srtd_frac_conv u_frac (
        .i_fraction     (r_s1.tx_fraction),
        .o_microseconds (frac_us)
    );

    // adding 2^31 when bit 31 is clear always leaves bit 31 set
    assign era_secs = {1'b1, r_s1.tx_seconds[30:0]} - UNIX_OFFSET;

    // reply checks: length, mode 4 or 5, leap bits 0 or 3
    assign too_long = r_s1.packet_length > MAX_PACKET_BYTES;
    assign mode_ok  = (r_s1.mode_byte[2:1] == 2'b10) &&
                      (r_s1.mode_byte[7:6] == 2'b00 || r_s1.mode_byte[7:6] == 2'b11);

    // action decode
    always_comb begin
        n_action = ACT_WRONG_MODE;
        n_secs   = '0;
        n_us     = '0;
        if (r_s1.opcode == OP_TICK) begin
            n_action = armed ? ACT_TICK_HOLD : ACT_TICK_REQ;
        end else if (too_long) begin
            n_action = ACT_TOO_LONG;
        end else if (!mode_ok) begin
            n_action = ACT_WRONG_MODE;
        end else if (r_s1.stratum == 8'd0) begin
            n_action = ACT_KOD;
        end else begin
            n_action = ACT_TIME_SET;
            n_secs   = signed'(era_secs);
            n_us     = frac_us;
        end
    end

    // holdoff tracker request
    assign hold_req.fire   = s1_adv;
    assign hold_req.tick   = (r_s1.opcode == OP_TICK);
    assign hold_req.kod    = (n_action == ACT_KOD);
    assign hold_req.now_us = r_s1.now_us;

    srtd_holdoff u_holdoff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hold_req),
        .o_armed (armed)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_action <= n_action;
            r_out_secs   <= n_secs;
            r_out_us     <= n_us;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_out_action;
    assign o_out.unix_seconds = r_out_secs;
    assign o_out.microseconds = r_out_us;

endmodule

`default_nettype wire

### rtl/core/srtd_checker.sv
// port-level checks for the sntp reply time decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module srtd_checker
    import srtd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [2:0]         i_out_action,
    input wire logic signed [31:0] i_out_unix_seconds,
    input wire logic [19:0]        i_out_microseconds
);

    // a stalled result item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_action)
            && $stable(i_out_unix_seconds) && $stable(i_out_microseconds))
        else $error("result item changed while stalled");

    // time fields are zero unless the time was set
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_action != ACT_TIME_SET |->
            i_out_unix_seconds == '0 && i_out_microseconds == '0)
        else $error("time fields set on a non time-set item");

    // converted fraction stays below one second
    a_us_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_microseconds <= 20'd999993)
        else $error("microseconds out of range");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind sntp_reply_time_decoder srtd_checker u_srtd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_action       (o_out.action),
    .i_out_unix_seconds (o_out.unix_seconds),
    .i_out_microseconds (o_out.microseconds)
);

`default_nettype wire
